>>> rtl/core/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfct assertion failed");

// next-cycle implication
`define SFCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfct assertion failed");

`endif

>>> rtl/core/sfct_pkg.sv
package sfct_pkg;

   localparam int KEY_WIDTH         = 8;
   localparam int HANDLE_PORT_WIDTH = 32;
   localparam int COUNT_PORT_WIDTH  = 3;
   localparam int REQ_TYPE_WIDTH    = 2;
   localparam int STATUS_WIDTH      = 2;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_INSERT  = 2'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_LOOKUP  = 2'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_REPLACE = 2'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_SCAN    = 2'd3;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_LOOKUP,
      OP_REPLACE,
      OP_SCAN
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_SCAN
   } back_state_type;

   typedef struct packed {
      op_type                       op;
      logic [KEY_WIDTH-1:0]         key;
      logic [HANDLE_PORT_WIDTH-1:0] child;
      logic [KEY_WIDTH-1:0]         low;
      logic [KEY_WIDTH-1:0]         high;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

>>> rtl/core/sfct_front.sv
module sfct_front (
   input  logic                                   req_valid,
   input  logic [sfct_pkg::REQ_TYPE_WIDTH-1:0]    req_type,
   input  logic [sfct_pkg::KEY_WIDTH-1:0]         req_key_value,
   input  logic [sfct_pkg::HANDLE_PORT_WIDTH-1:0] req_child_handle,
   input  logic [sfct_pkg::KEY_WIDTH-1:0]         req_low_bound,
   input  logic [sfct_pkg::KEY_WIDTH-1:0]         req_high_bound,
   output logic                                   req_stall,
   input  logic                                   queue_full,
   output logic                                   push,
   output sfct_pkg::cmd_type                      push_cmd
);
   import sfct_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_cmd.key   = req_key_value;
      push_cmd.child = req_child_handle;
      push_cmd.low   = req_low_bound;
      push_cmd.high  = req_high_bound;
      case (req_type)
         REQ_INSERT:  push_cmd.op = OP_INSERT;
         REQ_LOOKUP:  push_cmd.op = OP_LOOKUP;
         REQ_REPLACE: push_cmd.op = OP_REPLACE;
         REQ_SCAN:    push_cmd.op = OP_SCAN;
         default:     push_cmd.op = OP_LOOKUP;
      endcase
   end

endmodule

>>> rtl/core/sfct_queue.sv
module sfct_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sfct_pkg::cmd_type        push_cmd,
   output logic                     full,
   input  logic                     pop,
   output sfct_pkg::queue_head_type head
);
   import sfct_pkg::*;

   cmd_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/sfct_back.sv
module sfct_back #(
   parameter int ENTRIES      = 4,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sfct_pkg::queue_head_type               head,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [sfct_pkg::KEY_WIDTH-1:0]         rsp_key_out,
   output logic [sfct_pkg::HANDLE_PORT_WIDTH-1:0] rsp_child_out,
   output logic                                   rsp_last,
   output logic [sfct_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic                                   rsp_is_full,
   output logic [sfct_pkg::COUNT_PORT_WIDTH-1:0]  rsp_entry_count
);
   import sfct_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [KEY_WIDTH-1:0]         key_ff     [ENTRIES];
   logic [KEY_WIDTH-1:0]         key_in     [ENTRIES];
   logic [HANDLE_WIDTH-1:0]      child_ff   [ENTRIES];
   logic [HANDLE_WIDTH-1:0]      child_in   [ENTRIES];
   logic [KEY_WIDTH-1:0]         below_key  [ENTRIES];
   logic [HANDLE_WIDTH-1:0]      below_child[ENTRIES];
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [ENTRIES-1:0]           mask_ff, mask_in;
   back_state_type               state_ff, state_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff, found_in;
   logic [KEY_WIDTH-1:0]         key_out_ff, key_out_in;
   logic [HANDLE_PORT_WIDTH-1:0] child_out_ff, child_out_in;
   logic                         last_ff, last_in;
   status_type                   status_ff, status_in;
   logic                         full_ff, full_in;
   logic [COUNT_PORT_WIDTH-1:0]  count_ff, count_in;

   logic [ENTRIES-1:0]           in_use, stay, below_stay, match, qual, rest;
   logic [HANDLE_WIDTH-1:0]      new_child;
   logic [IDX_W-1:0]             hit_idx, top_idx;
   logic                         out_free, table_full, emit, walk;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (used_ff == CNT_W'(ENTRIES));
   assign new_child  = HANDLE_WIDTH'(head.cmd.child);

   // per-slot compares
   always_comb begin
      walk = 1'b1;
      for (int j = 0; j < ENTRIES; j++) begin
         in_use[j] = (CNT_W'(j) < used_ff);
         stay[j]   = in_use[j] && (head.cmd.key > key_ff[j]);
         match[j]  = in_use[j] && (key_ff[j] == head.cmd.key);
      end
      below_stay[0]  = 1'b1;
      below_key[0]   = key_ff[0];
      below_child[0] = child_ff[0];
      for (int j = 1; j < ENTRIES; j++) begin
         below_stay[j]  = stay[j-1];
         below_key[j]   = key_ff[j-1];
         below_child[j] = child_ff[j-1];
      end
      // scan walks down from the top and stops below the low bound
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         if (in_use[j]) begin
            walk = walk && (key_ff[j] >= head.cmd.low);
         end
         qual[j] = in_use[j] && walk && (key_ff[j] <= head.cmd.high);
      end
      hit_idx = '0;
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         if (match[j]) begin
            hit_idx = IDX_W'(j);
         end
      end
      top_idx = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (mask_ff[j]) begin
            top_idx = IDX_W'(j);
         end
      end
      rest          = mask_ff;
      rest[top_idx] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      used_in      = used_ff;
      key_in       = key_ff;
      child_in     = child_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      key_out_in   = key_out_ff;
      child_out_in = child_out_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (head.valid && out_free) begin
               pop          = 1'b1;
               found_in     = 1'b0;
               key_out_in   = head.cmd.key;
               child_out_in = '0;
               last_in      = 1'b1;
               status_in    = STATUS_OK;
               case (head.cmd.op)
                  OP_INSERT: begin
                     emit = 1'b1;
                     if (table_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        for (int j = 0; j < ENTRIES; j++) begin
                           if ((CNT_W'(j) <= used_ff) && !stay[j]) begin
                              if (below_stay[j]) begin
                                 key_in[j]   = head.cmd.key;
                                 child_in[j] = new_child;
                              end else begin
                                 key_in[j]   = below_key[j];
                                 child_in[j] = below_child[j];
                              end
                           end
                        end
                        used_in = used_ff + 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     emit = 1'b1;
                     if (|match) begin
                        found_in     = 1'b1;
                        child_out_in = HANDLE_PORT_WIDTH'(child_ff[hit_idx]);
                     end
                  end
                  OP_REPLACE: begin
                     emit = 1'b1;
                     if (|match) begin
                        child_in[hit_idx] = new_child;
                        child_out_in      = HANDLE_PORT_WIDTH'(new_child);
                     end else begin
                        status_in = STATUS_ABSENT;
                     end
                  end
                  OP_SCAN: begin
                     mask_in  = qual;
                     state_in = BACK_SCAN;
                  end
                  default: begin
                     state_in = BACK_IDLE;
                  end
               endcase
            end
         end
         BACK_SCAN: begin
            if (out_free) begin
               emit      = 1'b1;
               status_in = STATUS_OK;
               if (mask_ff == '0) begin
                  found_in     = 1'b0;
                  key_out_in   = '0;
                  child_out_in = '0;
                  last_in      = 1'b1;
                  state_in     = BACK_IDLE;
               end else begin
                  found_in     = 1'b1;
                  key_out_in   = key_ff[top_idx];
                  child_out_in = HANDLE_PORT_WIDTH'(child_ff[top_idx]);
                  last_in      = (rest == '0);
                  mask_in      = rest;
                  if (rest == '0) begin
                     state_in = BACK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
         full_in      = (used_in >= CNT_W'(ENTRIES));
         count_in     = COUNT_PORT_WIDTH'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      child_ff     <= child_in;
      mask_ff      <= mask_in;
      found_ff     <= found_in;
      key_out_ff   <= key_out_in;
      child_out_ff <= child_out_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
      full_ff      <= full_in;
      count_ff     <= count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_child_out   = child_out_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_entry_count = count_ff;

endmodule

>>> rtl/core/sorted_four_entry_child_table.sv
// Sorted table of up to ENTRIES (key byte, child handle) pairs in ascending key order.
// Request words are decoded in the front part and wait in a two-word queue, so a
// new request is taken every cycle while the queue has room. The back part owns the
// table and runs one request at a time: insert, lookup and replace each give one
// result word; a range scan first marks the matching slots and then gives one result
// word per matching slot (one word for an empty scan), highest key first. Results sit
// in an output register; while a finished word is held by rsp_stall the back part
// waits, and once the queue is full req_stall rises. Handles are kept to HANDLE_WIDTH
// bits. An insert into a full table and a replace of an absent key report a status
// code and leave the table unchanged.
module sorted_four_entry_child_table #(
   parameter int ENTRIES      = 4,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sfct_pkg::REQ_TYPE_WIDTH-1:0]    req_type,
   input  logic [sfct_pkg::KEY_WIDTH-1:0]         req_key_value,
   input  logic [sfct_pkg::HANDLE_PORT_WIDTH-1:0] req_child_handle,
   input  logic [sfct_pkg::KEY_WIDTH-1:0]         req_low_bound,
   input  logic [sfct_pkg::KEY_WIDTH-1:0]         req_high_bound,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [sfct_pkg::KEY_WIDTH-1:0]         rsp_key_out,
   output logic [sfct_pkg::HANDLE_PORT_WIDTH-1:0] rsp_child_out,
   output logic                                   rsp_last,
   output logic [sfct_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic                                   rsp_is_full,
   output logic [sfct_pkg::COUNT_PORT_WIDTH-1:0]  rsp_entry_count
);
   import sfct_pkg::*;

   `include "assert_macros.svh"

   logic           push, queue_full, pop;
   cmd_type        push_cmd;
   queue_head_type head;

   sfct_front u_front (
      .req_valid        (req_valid),
      .req_type         (req_type),
      .req_key_value    (req_key_value),
      .req_child_handle (req_child_handle),
      .req_low_bound    (req_low_bound),
      .req_high_bound   (req_high_bound),
      .req_stall        (req_stall),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   sfct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   sfct_back #(
      .ENTRIES      (ENTRIES),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_key_out     (rsp_key_out),
      .rsp_child_out   (rsp_child_out),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_is_full     (rsp_is_full),
      .rsp_entry_count (rsp_entry_count)
   );

   `SFCT_ASSERT_NOW(a_pop_needs_word, clock, reset, pop, head.valid)
   `SFCT_ASSERT_NOW(a_full_status_is_full, clock, reset,
      rsp_valid && (rsp_status == STATUS_FULL), rsp_is_full)
   `SFCT_ASSERT_NOW(a_more_words_carry_entry, clock, reset,
      rsp_valid && !rsp_last, rsp_found)
   `SFCT_ASSERT_NOW(a_absent_has_no_child, clock, reset,
      rsp_valid && (rsp_status == STATUS_ABSENT), (rsp_child_out == '0) && !rsp_found)

endmodule

>>> tb/sorted_four_entry_child_table_tb.sv
module sorted_four_entry_child_table_tb;
   import sfct_pkg::*;

   localparam int TBL_ENTRIES  = 4;
   localparam int RANDOM_ITEMS = 190;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 90;
   localparam int DRAIN_CYCLES = 30;
   localparam int RUN_LIMIT    = 200000;

   typedef struct packed {
      logic                         found;
      logic [KEY_WIDTH-1:0]         key;
      logic [HANDLE_PORT_WIDTH-1:0] child;
      logic                         last;
      status_type                   status;
      logic                         full;
      logic [COUNT_PORT_WIDTH-1:0]  count;
   } table_word_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [REQ_TYPE_WIDTH-1:0]    req_type = OP_LOOKUP;
   logic [KEY_WIDTH-1:0]         req_key_value = '0;
   logic [HANDLE_PORT_WIDTH-1:0] req_child_handle = '0;
   logic [KEY_WIDTH-1:0]         req_low_bound = '0;
   logic [KEY_WIDTH-1:0]         req_high_bound = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_found;
   logic [KEY_WIDTH-1:0]         rsp_key_out;
   logic [HANDLE_PORT_WIDTH-1:0] rsp_child_out;
   logic                         rsp_last;
   logic [STATUS_WIDTH-1:0]      rsp_status;
   logic                         rsp_is_full;
   logic [COUNT_PORT_WIDTH-1:0]  rsp_entry_count;

   sorted_four_entry_child_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key_value(req_key_value),
      .req_child_handle(req_child_handle),
      .req_low_bound(req_low_bound),
      .req_high_bound(req_high_bound),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_key_out(rsp_key_out),
      .rsp_child_out(rsp_child_out),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status),
      .rsp_is_full(rsp_is_full),
      .rsp_entry_count(rsp_entry_count)
   );

   always #2 clock = ~clock;

   // shadow copy of the table
   logic [KEY_WIDTH-1:0]         tbl_keys     [TBL_ENTRIES];
   logic [HANDLE_PORT_WIDTH-1:0] tbl_children [TBL_ENTRIES];
   int                           tbl_count;

   cmd_type     requests_to_send [$];
   table_word_t table_words_due  [$];

   cmd_type     offered;
   cmd_type     next_req;
   table_word_t seen;
   table_word_t want;
   int          gap_left;
   int          burst_left;
   int          requests_taken;
   int          words_checked;
   int          mismatches;
   int          cycle_count;
   int          op_tally [4];
   int          full_inserts;
   int          absent_replaces;
   int          empty_scans;
   int          scan_hits;
   int          stall_mode;
   int          mode_left;
   int          hold_left;
   logic        hold_used;

   initial begin
      for (int i = 0; i < TBL_ENTRIES; i++) begin
         tbl_keys[i]     = '0;
         tbl_children[i] = '0;
      end
      tbl_count       = 0;
      gap_left        = 0;
      burst_left      = 4;
      requests_taken  = 0;
      words_checked   = 0;
      mismatches      = 0;
      cycle_count     = 0;
      op_tally        = '{0, 0, 0, 0};
      full_inserts    = 0;
      absent_replaces = 0;
      empty_scans     = 0;
      scan_hits       = 0;
      stall_mode      = 0;
      mode_left       = 0;
      hold_left       = 0;
      hold_used       = 1'b0;
   end

   function automatic string word_text(table_word_t w);
      return $sformatf("found=%0d key=%02h child=%08h last=%0d status=%0d full=%0d count=%0d",
                       w.found, w.key, w.child, w.last, w.status, w.full, w.count);
   endfunction

   function automatic void push_word(table_word_t w);
      w.full  = (tbl_count == TBL_ENTRIES);
      w.count = tbl_count[COUNT_PORT_WIDTH-1:0];
      table_words_due.push_back(w);
   endfunction

   function automatic void compute_table_words(cmd_type c);
      table_word_t w;
      table_word_t hits [$];
      int          slot;
      logic        hit;
      w        = '0;
      w.key    = c.key;
      w.last   = 1'b1;
      w.status = STATUS_OK;
      hit      = 1'b0;
      op_tally[c.op]++;
      case (c.op)
         OP_INSERT: begin
            if (tbl_count == TBL_ENTRIES) begin
               w.status = STATUS_FULL;
               full_inserts++;
            end else begin
               slot = 0;
               while (slot < tbl_count && c.key > tbl_keys[slot]) slot++;
               for (int i = tbl_count; i > slot; i--) begin
                  tbl_keys[i]     = tbl_keys[i-1];
                  tbl_children[i] = tbl_children[i-1];
               end
               tbl_keys[slot]     = c.key;
               tbl_children[slot] = c.child;
               tbl_count++;
            end
            push_word(w);
         end
         OP_LOOKUP: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (!hit && tbl_keys[i] == c.key) begin
                  hit     = 1'b1;
                  w.found = 1'b1;
                  w.child = tbl_children[i];
               end
            end
            push_word(w);
         end
         OP_REPLACE: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (!hit && tbl_keys[i] == c.key) begin
                  hit             = 1'b1;
                  tbl_children[i] = c.child;
                  w.child         = c.child;
               end
            end
            if (!hit) begin
               w.status = STATUS_ABSENT;
               absent_replaces++;
            end
            push_word(w);
         end
         default: begin
            // walk down from the top slot, stop below the low bound
            slot = tbl_count;
            while (slot > 0 && tbl_keys[slot-1] >= c.low) begin
               slot--;
               if (tbl_keys[slot] <= c.high) begin
                  w.found = 1'b1;
                  w.key   = tbl_keys[slot];
                  w.child = tbl_children[slot];
                  w.last  = 1'b0;
                  hits.push_back(w);
               end
            end
            if (hits.size() == 0) begin
               w     = '0;
               w.last = 1'b1;
               empty_scans++;
               push_word(w);
            end else begin
               hits[hits.size()-1].last = 1'b1;
               scan_hits += hits.size();
               foreach (hits[i]) push_word(hits[i]);
            end
         end
      endcase
   endfunction

   function automatic void add_req(op_type op, logic [7:0] key, logic [31:0] child,
                                   logic [7:0] low, logic [7:0] high);
      cmd_type c;
      c.op    = op;
      c.key   = key;
      c.child = child;
      c.low   = low;
      c.high  = high;
      requests_to_send.push_back(c);
   endfunction

   function automatic cmd_type random_request();
      cmd_type    c;
      int         pick;
      logic [7:0] held_keys [3];
      held_keys = '{8'h00, 8'h80, 8'hff};
      pick      = $urandom_range(0, 99);
      if (pick < 15)      c.op = OP_INSERT;
      else if (pick < 45) c.op = OP_LOOKUP;
      else if (pick < 65) c.op = OP_REPLACE;
      else                c.op = OP_SCAN;
      c.key   = ($urandom_range(0, 9) < 7) ? held_keys[$urandom_range(0, 2)] : 8'($urandom);
      c.child = $urandom;
      c.low   = 8'($urandom);
      c.high  = 8'($urandom);
      if (c.op == OP_SCAN) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            c.low  = 8'($urandom_range(0, 128));
            c.high = 8'($urandom_range(128, 255));
         end else if (pick < 6) begin
            c.low  = 8'($urandom_range(1, 255));
            c.high = 8'($urandom_range(0, c.low - 1));
         end else if (pick < 7) begin
            c.low  = held_keys[$urandom_range(0, 2)];
            c.high = c.low;
         end
      end
      return c;
   endfunction

   // stimulus and end of run
   initial begin
      add_req(OP_LOOKUP,  8'h00, 32'h0000_0000, 8'h00, 8'hff);
      add_req(OP_REPLACE, 8'h55, 32'h1111_1111, 8'h00, 8'h00);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'h00, 8'hff);
      add_req(OP_INSERT,  8'h80, 32'hffff_ffff, 8'h00, 8'h00);
      add_req(OP_INSERT,  8'h00, 32'h0000_0000, 8'hff, 8'hff);
      add_req(OP_SCAN,    8'hff, 32'hffff_ffff, 8'h00, 8'hff);
      add_req(OP_INSERT,  8'h80, 32'h1234_5678, 8'h00, 8'h00);
      add_req(OP_LOOKUP,  8'h80, 32'h0000_0000, 8'h00, 8'h00);
      add_req(OP_REPLACE, 8'h80, 32'ha5a5_a5a5, 8'h00, 8'h00);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'h00, 8'hff);
      add_req(OP_INSERT,  8'hff, 32'hdead_beef, 8'h00, 8'h00);
      add_req(OP_INSERT,  8'h40, 32'h5a5a_5a5a, 8'h00, 8'h00);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'h00, 8'hff);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'h81, 8'hfe);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'h80, 8'h80);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'hc8, 8'h0a);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'h00, 8'h00);
      add_req(OP_SCAN,    8'h00, 32'h0000_0000, 8'hff, 8'hff);
      add_req(OP_LOOKUP,  8'hff, 32'h0000_0000, 8'h00, 8'h00);
      add_req(OP_LOOKUP,  8'h7f, 32'h0000_0000, 8'h00, 8'h00);
      add_req(OP_REPLACE, 8'h00, 32'hffff_ffff, 8'h00, 8'h00);
      add_req(OP_REPLACE, 8'h01, 32'h0f0f_0f0f, 8'h00, 8'h00);
      add_req(OP_LOOKUP,  8'h00, 32'h0000_0000, 8'hff, 8'h00);
      for (int i = 0; i < RANDOM_ITEMS; i++) requests_to_send.push_back(random_request());

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (requests_to_send.size() != 0 || req_valid || table_words_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      mismatches += table_words_due.size();

      $display("covered %0d requests: %0d insert, %0d lookup, %0d replace, %0d scan",
               requests_taken, op_tally[OP_INSERT], op_tally[OP_LOOKUP],
               op_tally[OP_REPLACE], op_tally[OP_SCAN]);
      $display("%0d words checked: %0d full inserts, %0d absent replaces, %0d scan hits, %0d empty scans",
               words_checked, full_inserts, absent_replaces, scan_hits, empty_scans);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // request driver, bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_table_words(offered);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (requests_to_send.size() > 0) begin
               next_req = requests_to_send.pop_front();
               offered          <= next_req;
               req_type         <= next_req.op;
               req_key_value    <= next_req.key;
               req_child_handle <= next_req.child;
               req_low_bound    <= next_req.low;
               req_high_bound   <= next_req.high;
               req_valid        <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                  burst_left = $urandom_range(1, 24);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall pattern with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_used && requests_taken >= HOLD_AFTER) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(8, 40);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.found  = rsp_found;
         seen.key    = rsp_key_out;
         seen.child  = rsp_child_out;
         seen.last   = rsp_last;
         seen.status = status_type'(rsp_status);
         seen.full   = rsp_is_full;
         seen.count  = rsp_entry_count;
         if (table_words_due.size() == 0) begin
            if (mismatches < 10) $display("unexpected result word: %s", word_text(seen));
            mismatches++;
         end else begin
            want = table_words_due.pop_front();
            words_checked++;
            if (seen !== want) begin
               if (mismatches < 10) begin
                  $display("result word %0d mismatch", words_checked);
                  $display("  expected %s", word_text(want));
                  $display("  actual   %s", word_text(seen));
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
